[rtl/core/pgn_byte_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// pgn_byte_tokenizer assertion macros
// Shared checks for the tokenizer modules; they assume clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PGN_BYTE_TOKENIZER_DEFINES_SVH
`define PGN_BYTE_TOKENIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define PGNT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PGNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pgnt_pkg.sv]
// ----------------------------------------------------------------------------
// pgnt_pkg
// Token kinds, token and command types shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package pgnt_pkg;

  localparam int DIGIT_DEPTH_DEF = 8;
  // A flush of digits plus its follower must fit the results of one byte
  localparam int DIGIT_CAP       = 9;
  localparam int MAX_RESULTS     = 10;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_MOVE    = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_OUTCOME = 3'd4;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic [2:0] tok_kind;
    logic       end_mark;
  } tok_t;

  // Plain results of one byte, issued after any flushed digits
  typedef struct packed {
    logic [1:0]       nplain;
    tok_t [1:0]       plain;
  } cmd_head_t;

endpackage

[rtl/core/pgnt_front.sv]
// ----------------------------------------------------------------------------
// pgnt_front
// Lexer: takes one text byte per cycle while the queue has room and turns it into a result command.
// ----------------------------------------------------------------------------
`include "pgn_byte_tokenizer_defines.svh"

module pgnt_front #(
  parameter int  DIGIT_DEPTH = pgnt_pkg::DIGIT_DEPTH_DEF,
  localparam int DigLim      = (DIGIT_DEPTH < pgnt_pkg::DIGIT_CAP) ? DIGIT_DEPTH
                                                                   : pgnt_pkg::DIGIT_CAP,
  localparam int CntW        = $clog2(DigLim + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  input  logic                    in_eot,
  output logic                    q_push,
  input  logic                    q_ready,
  output pgnt_pkg::cmd_head_t     q_head,
  output logic [DigLim*4-1:0]     q_digits,
  output logic [CntW-1:0]         q_ndig
);
  import pgnt_pkg::*;

  localparam int StIdxW = (DigLim > 1) ? $clog2(DigLim) : 1;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KEY, ST_SKIP_QUOTE, ST_VALUE, ST_SKIP_BRACKET, ST_COMMENT,
    ST_DIGITS, ST_OUT_ONE, ST_OUT_WORD, ST_SCAN, ST_MOVE
  } mode_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_move_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h68], [8'h31:8'h38], 8'h4E, 8'h42, 8'h52, 8'h51,
                     8'h4B, 8'h4F, 8'h30, 8'h2D, 8'h2B, 8'h23};
  endfunction

  function automatic logic [2:0] kind_of(input mode_t m);
    logic [2:0] k;
    case (m)
      ST_KEY:     k = KIND_KEY;
      ST_VALUE:   k = KIND_VALUE;
      ST_MOVE:    k = KIND_MOVE;
      ST_COMMENT: k = KIND_COMMENT;
      default:    k = KIND_OUTCOME;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_byte(input logic [7:0] c, input logic [2:0] k);
    tok_t t;
    t.tok_byte = c;
    t.tok_kind = k;
    t.end_mark = 1'b0;
    return t;
  endfunction

  function automatic tok_t mk_end(input logic [2:0] k);
    tok_t t;
    t.tok_byte = '0;
    t.tok_kind = k;
    t.end_mark = 1'b1;
    return t;
  endfunction

  mode_t             mode_r, mode_nxt;
  logic              open_r, open_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [3:0]        store_r [DigLim];
  logic              st_we;
  logic [StIdxW-1:0] st_waddr;
  logic              acc;

  // Idle handling, shared by idle mode and a digit run with another follower
  mode_t idle_mode;
  logic  idle_open, idle_emit, idle_dig;

  logic [1:0]      np;
  logic [3:0]      sum;
  tok_t            t0, t1;
  logic [CntW-1:0] ndig;

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;

  always_comb begin
    idle_open = 1'b0;
    idle_emit = 1'b0;
    idle_dig  = 1'b0;
    if (in_byte == CH_LBRACK) begin
      idle_mode = ST_KEY;
      idle_open = 1'b1;
    end else if (in_byte == CH_LBRACE) begin
      idle_mode = ST_COMMENT;
      idle_open = 1'b1;
    end else if (is_dig(in_byte)) begin
      idle_mode = ST_DIGITS;
      idle_dig  = 1'b1;
    end else if (is_ws(in_byte) || in_byte == CH_NUL) begin
      idle_mode = ST_IDLE;
    end else if (is_move_letter(in_byte)) begin
      idle_mode = ST_MOVE;
      idle_open = 1'b1;
      idle_emit = 1'b1;
    end else begin
      idle_mode = ST_SCAN;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    open_nxt = open_r;
    cnt_nxt  = cnt_r;
    st_we    = 1'b0;
    st_waddr = cnt_r[StIdxW-1:0];
    np       = 2'd0;
    t0       = '0;
    t1       = '0;
    ndig     = '0;
    case (mode_r)
      ST_KEY: begin
        np = 2'd1;
        if (is_ws(in_byte)) begin
          t0       = mk_end(KIND_KEY);
          open_nxt = 1'b0;
          mode_nxt = ST_SKIP_QUOTE;
        end else begin
          t0 = mk_byte(in_byte, KIND_KEY);
        end
      end
      ST_SKIP_QUOTE: begin
        mode_nxt = ST_VALUE;
        open_nxt = 1'b1;
      end
      ST_VALUE: begin
        np = 2'd1;
        if (in_byte == CH_QUOTE) begin
          t0       = mk_end(KIND_VALUE);
          open_nxt = 1'b0;
          mode_nxt = ST_SKIP_BRACKET;
        end else begin
          t0 = mk_byte(in_byte, KIND_VALUE);
        end
      end
      ST_SKIP_BRACKET: begin
        mode_nxt = ST_IDLE;
      end
      ST_COMMENT: begin
        np = 2'd1;
        if (in_byte == CH_RBRACE) begin
          t0       = mk_end(KIND_COMMENT);
          open_nxt = 1'b0;
          mode_nxt = ST_IDLE;
        end else begin
          t0 = mk_byte(in_byte, KIND_COMMENT);
        end
      end
      ST_DIGITS: begin
        if (is_dig(in_byte)) begin
          // Drop digits beyond the store depth
          if (cnt_r < CntW'(DigLim)) begin
            st_we   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (in_byte == CH_DOT) begin
          cnt_nxt  = '0;
          mode_nxt = ST_IDLE;
        end else if (in_byte == CH_DASH || in_byte == CH_SLASH) begin
          ndig     = cnt_r;
          t0       = mk_byte(in_byte, KIND_OUTCOME);
          np       = 2'd1;
          cnt_nxt  = '0;
          open_nxt = 1'b1;
          mode_nxt = (in_byte == CH_DASH) ? ST_OUT_ONE : ST_OUT_WORD;
        end else begin
          cnt_nxt  = '0;
          mode_nxt = idle_mode;
          if (idle_open) open_nxt = 1'b1;
          if (idle_emit) begin
            t0 = mk_byte(in_byte, KIND_MOVE);
            np = 2'd1;
          end
        end
      end
      ST_OUT_ONE: begin
        t0       = mk_byte(in_byte, KIND_OUTCOME);
        t1       = mk_end(KIND_OUTCOME);
        np       = 2'd2;
        open_nxt = 1'b0;
        mode_nxt = ST_IDLE;
      end
      ST_OUT_WORD: begin
        np = 2'd1;
        if (is_ws(in_byte)) begin
          t0       = mk_end(KIND_OUTCOME);
          open_nxt = 1'b0;
          mode_nxt = ST_IDLE;
        end else begin
          t0 = mk_byte(in_byte, KIND_OUTCOME);
        end
      end
      ST_SCAN: begin
        if (is_ws(in_byte) || in_byte == CH_NUL) begin
          mode_nxt = ST_IDLE;
        end else if (is_move_letter(in_byte)) begin
          t0       = mk_byte(in_byte, KIND_MOVE);
          np       = 2'd1;
          open_nxt = 1'b1;
          mode_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        np = 2'd1;
        if (is_ws(in_byte)) begin
          t0       = mk_end(KIND_MOVE);
          open_nxt = 1'b0;
          mode_nxt = ST_IDLE;
        end else begin
          t0 = mk_byte(in_byte, KIND_MOVE);
        end
      end
      default: begin
        mode_nxt = idle_mode;
        if (idle_open) open_nxt = 1'b1;
        if (idle_emit) begin
          t0 = mk_byte(in_byte, KIND_MOVE);
          np = 2'd1;
        end
        if (idle_dig) begin
          st_we    = 1'b1;
          st_waddr = '0;
          cnt_nxt  = CntW'(1);
        end
      end
    endcase

    // Close any open token on the final byte of the text
    if (in_eot) begin
      if (open_nxt) begin
        if (np == 2'd0) t0 = mk_end(kind_of(mode_nxt));
        else            t1 = mk_end(kind_of(mode_nxt));
        np = np + 2'd1;
      end
      mode_nxt = ST_IDLE;
      cnt_nxt  = '0;
      open_nxt = 1'b0;
    end

    // Trim the tail when digits and followers exceed the per-byte limit
    sum = 4'(ndig) + 4'(np);
    if (sum > 4'(MAX_RESULTS)) np = 2'(4'(MAX_RESULTS) - 4'(ndig));
  end

  always_comb begin
    for (int i = 0; i < DigLim; i++) q_digits[i*4 +: 4] = store_r[i];
  end

  assign q_head.nplain   = np;
  assign q_head.plain[0] = t0;
  assign q_head.plain[1] = t1;
  assign q_ndig          = ndig;
  assign q_push          = acc && (np != 2'd0 || ndig != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ST_IDLE;
      open_r <= 1'b0;
      cnt_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Digits keep only their low nibble
  always_ff @(posedge clk) begin
    if (acc && st_we) store_r[st_waddr] <= in_byte[3:0];
  end

  `PGNT_ASSERT_SAME(a_front_cnt_range, 1'b1, cnt_r <= CntW'(DigLim), "digit count beyond store depth")
  `PGNT_ASSERT_NEXT(a_front_eot_idle, acc && in_eot, mode_r == ST_IDLE && !open_r && cnt_r == '0, "lexer not idle after end of text")

endmodule

[rtl/core/pgnt_queue.sv]
// ----------------------------------------------------------------------------
// pgnt_queue
// Short command queue between lexer and result sequencer.
// ----------------------------------------------------------------------------
`include "pgn_byte_tokenizer_defines.svh"

module pgnt_queue #(
  parameter int W     = 8,
  parameter int DEPTH = pgnt_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] count_r;

  assign ready = count_r != CntW'(DEPTH);
  assign valid = count_r != '0;
  assign rdata = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
  end

  `PGNT_ASSERT_SAME(a_queue_no_overflow, push, count_r != CntW'(DEPTH), "push into full queue")
  `PGNT_ASSERT_SAME(a_queue_no_underflow, pop, count_r != '0, "pop from empty queue")

endmodule

[rtl/core/pgnt_back.sv]
// ----------------------------------------------------------------------------
// pgnt_back
// Result sequencer: expands one command into result transactions.
// ----------------------------------------------------------------------------
`include "pgn_byte_tokenizer_defines.svh"

module pgnt_back #(
  parameter int  DIGIT_DEPTH = pgnt_pkg::DIGIT_DEPTH_DEF,
  localparam int DigLim      = (DIGIT_DEPTH < pgnt_pkg::DIGIT_CAP) ? DIGIT_DEPTH
                                                                   : pgnt_pkg::DIGIT_CAP,
  localparam int CntW        = $clog2(DigLim + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  pgnt_pkg::cmd_head_t q_head,
  input  logic [DigLim*4-1:0] q_digits,
  input  logic [CntW-1:0]     q_ndig,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [2:0]          out_kind,
  output logic                out_end,
  output logic                out_last
);
  import pgnt_pkg::*;

  localparam int StIdxW = (DigLim > 1) ? $clog2(DigLim) : 1;

  logic [3:0]        idx_r;
  logic [3:0]        total;
  logic [3:0]        pidx;
  logic [StIdxW-1:0] didx;
  logic              load, last;
  tok_t              sel;
  logic              valid_r, last_r, end_r;
  logic [7:0]        byte_r;
  logic [2:0]        kind_r;

  assign total = 4'(q_ndig) + 4'(q_head.nplain);
  assign last  = idx_r == total - 4'd1;
  assign load  = q_valid && (!valid_r || out_ready);
  assign q_pop = load && last;
  assign pidx  = idx_r - 4'(q_ndig);
  assign didx  = idx_r[StIdxW-1:0];

  // Digits first, then the plain results
  always_comb begin
    if (idx_r < 4'(q_ndig)) begin
      sel.tok_byte = {4'h3, q_digits[didx*4 +: 4]};
      sel.tok_kind = KIND_OUTCOME;
      sel.end_mark = 1'b0;
    end else begin
      sel = q_head.plain[pidx[0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? '0 : idx_r + 4'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel.tok_byte;
      kind_r <= sel.tok_kind;
      end_r  <= sel.end_mark;
      last_r <= last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_end   = end_r;
  assign out_last  = last_r;

  `PGNT_ASSERT_SAME(a_back_idx_range, q_valid, idx_r < total, "result index past command end")
  `PGNT_ASSERT_NEXT(a_back_cmd_held, load && !last, q_valid, "command left before its last result")

endmodule

[rtl/core/pgn_byte_tokenizer.sv]
// ----------------------------------------------------------------------------
// pgn_byte_tokenizer
// Game-record text tokenizer: text bytes in, tagged token bytes out.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transaction on in_tdata, in_tlast on the
// final byte of the text. Output stream: one token byte or end marker per
// transaction; out_tuser carries the token kind and the end-marker flag,
// out_tlast marks the last result caused by one input byte.
// A byte is accepted every cycle while the command queue has room; a byte
// that causes no result leaves nothing behind. A byte causes n results
// (n is at most 10, reached when a run of buffered digits is flushed as an
// outcome); the sustained rate is one result per cycle while the receiver
// is ready, set by the output register of the result sequencer.
// An accepted byte's command passes the queue, then the output register.
// When the receiver stalls, the output register holds its transaction, the
// four-entry queue fills, and in_tready then drops.
// Reset (synchronous, active low) returns the lexer to idle with no token
// open and no digits buffered, and empties the queue and output register.
// ----------------------------------------------------------------------------
module pgn_byte_tokenizer #(
  parameter int DIGIT_DEPTH = pgnt_pkg::DIGIT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tok_byte
  output logic [3:0] out_tuser,  // [2:0] tok_kind, [3] is_end_marker
  output logic       out_tlast   // run_last
);
  import pgnt_pkg::*;

  localparam int DigLim = (DIGIT_DEPTH < DIGIT_CAP) ? DIGIT_DEPTH : DIGIT_CAP;
  localparam int CntW   = $clog2(DigLim + 1);
  localparam int HeadW  = $bits(cmd_head_t);
  localparam int QW     = CntW + DigLim * 4 + HeadW;

  logic                q_push, q_ready, q_pop, q_valid;
  cmd_head_t           f_head, b_head;
  logic [DigLim*4-1:0] f_digits, b_digits;
  logic [CntW-1:0]     f_ndig, b_ndig;
  logic [QW-1:0]       q_wdata, q_rdata;
  logic [2:0]          kind;
  logic                end_mark;

  pgnt_front #(.DIGIT_DEPTH(DIGIT_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_eot   (in_tlast),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_head   (f_head),
    .q_digits (f_digits),
    .q_ndig   (f_ndig)
  );

  assign q_wdata = {f_ndig, f_digits, f_head};

  pgnt_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign {b_ndig, b_digits, b_head} = q_rdata;

  pgnt_back #(.DIGIT_DEPTH(DIGIT_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (b_head),
    .q_digits  (b_digits),
    .q_ndig    (b_ndig),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_kind  (kind),
    .out_end   (end_mark),
    .out_last  (out_tlast)
  );

  assign out_tuser = {end_mark, kind};

endmodule

[tb/sv/pgn_tok_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgn_tok_tb_pkg
// Token predictor and scoreboard for the game-record tokenizer testbench:
// a lexer tracking model that turns each accepted text byte into the token
// transactions it should cause, and a check of each output transaction.
// ----------------------------------------------------------------------------
package pgn_tok_tb_pkg;

  import pgnt_pkg::*;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_DASH     = 8'h2d;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;

  localparam int DIGIT_KEEP = (DIGIT_DEPTH_DEF < DIGIT_CAP) ? DIGIT_DEPTH_DEF : DIGIT_CAP;

  typedef enum logic [3:0] {
    LX_IDLE, LX_KEY, LX_SKIP_QUOTE, LX_VALUE, LX_SKIP_BRACKET,
    LX_COMMENT, LX_DIGITS, LX_OUT_ONE, LX_OUT_WORD, LX_SCAN, LX_MOVE
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic [2:0] tok_kind;
    logic       end_mark;
    logic       run_last;
  } tok_exp_t;

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_move_char(logic [7:0] c);
    if (c >= "a" && c <= "h") return 1'b1;
    if (c >= "1" && c <= "8") return 1'b1;
    case (c)
      "N", "B", "R", "Q", "K", "O", "0", CH_DASH, CH_PLUS, CH_HASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  class pgn_token_predictor;
    lex_mode_e  mode;
    logic [7:0] digit_buf [16];
    int         ndigits;
    bit         tok_open;
    tok_exp_t   byte_toks [$];
    tok_exp_t   pending_toks [$];
    int         errors;

    function new();
      mode     = LX_IDLE;
      ndigits  = 0;
      tok_open = 1'b0;
      errors   = 0;
    endfunction

    function void push_tok(logic [7:0] b, logic [2:0] k, logic e);
      tok_exp_t t;
      if (byte_toks.size() >= MAX_RESULTS) return;
      t.tok_byte = b;
      t.tok_kind = k;
      t.end_mark = e;
      t.run_last = 1'b0;
      byte_toks.push_back(t);
    endfunction

    function void close_tok(logic [2:0] k);
      push_tok(8'h00, k, 1'b1);
      tok_open = 1'b0;
      mode     = LX_IDLE;
    endfunction

    function void start_move(logic [7:0] c);
      mode     = LX_MOVE;
      tok_open = 1'b1;
      push_tok(c, KIND_MOVE, 1'b0);
    endfunction

    function void idle_byte(logic [7:0] c);
      if (c == CH_LBRACKET) begin
        mode     = LX_KEY;
        tok_open = 1'b1;
      end else if (c == CH_LBRACE) begin
        mode     = LX_COMMENT;
        tok_open = 1'b1;
      end else if (is_numeral(c)) begin
        mode         = LX_DIGITS;
        digit_buf[0] = c;
        ndigits      = 1;
      end else if (is_space(c) || c == CH_NUL) begin
        mode = LX_IDLE;
      end else if (is_move_char(c)) begin
        start_move(c);
      end else begin
        mode = LX_SCAN;
      end
    endfunction

    function logic [2:0] open_kind();
      case (mode)
        LX_KEY:     return KIND_KEY;
        LX_VALUE:   return KIND_VALUE;
        LX_MOVE:    return KIND_MOVE;
        LX_COMMENT: return KIND_COMMENT;
        default:    return KIND_OUTCOME;
      endcase
    endfunction

    // Note one accepted text byte and queue the tokens it causes
    function void take_byte(logic [7:0] c, logic eot);
      byte_toks.delete();
      case (mode)
        LX_KEY: begin
          if (is_space(c)) begin
            close_tok(KIND_KEY);
            mode = LX_SKIP_QUOTE;
          end else push_tok(c, KIND_KEY, 1'b0);
        end
        LX_SKIP_QUOTE: begin
          mode     = LX_VALUE;
          tok_open = 1'b1;
        end
        LX_VALUE: begin
          if (c == CH_QUOTE) begin
            close_tok(KIND_VALUE);
            mode = LX_SKIP_BRACKET;
          end else push_tok(c, KIND_VALUE, 1'b0);
        end
        LX_SKIP_BRACKET: mode = LX_IDLE;
        LX_COMMENT: begin
          if (c == CH_RBRACE) close_tok(KIND_COMMENT);
          else push_tok(c, KIND_COMMENT, 1'b0);
        end
        LX_DIGITS: begin
          if (is_numeral(c)) begin
            // drop digits beyond the store
            if (ndigits < DIGIT_KEEP) begin
              digit_buf[ndigits] = c;
              ndigits++;
            end
          end else if (c == CH_DOT) begin
            ndigits = 0;
            mode    = LX_IDLE;
          end else if (c == CH_DASH || c == CH_SLASH) begin
            for (int i = 0; i < ndigits; i++) push_tok(digit_buf[i], KIND_OUTCOME, 1'b0);
            ndigits = 0;
            push_tok(c, KIND_OUTCOME, 1'b0);
            tok_open = 1'b1;
            mode     = (c == CH_DASH) ? LX_OUT_ONE : LX_OUT_WORD;
          end else begin
            ndigits = 0;
            idle_byte(c);
          end
        end
        LX_OUT_ONE: begin
          push_tok(c, KIND_OUTCOME, 1'b0);
          close_tok(KIND_OUTCOME);
        end
        LX_OUT_WORD: begin
          if (is_space(c)) close_tok(KIND_OUTCOME);
          else push_tok(c, KIND_OUTCOME, 1'b0);
        end
        LX_SCAN: begin
          if (is_space(c) || c == CH_NUL) mode = LX_IDLE;
          else if (is_move_char(c)) start_move(c);
        end
        LX_MOVE: begin
          if (is_space(c)) close_tok(KIND_MOVE);
          else push_tok(c, KIND_MOVE, 1'b0);
        end
        default: idle_byte(c);
      endcase

      if (eot) begin
        if (tok_open) close_tok(open_kind());
        mode     = LX_IDLE;
        ndigits  = 0;
        tok_open = 1'b0;
      end

      if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].run_last = 1'b1;
      foreach (byte_toks[i]) pending_toks.push_back(byte_toks[i]);
    endfunction

    function void match_tok(logic [7:0] b, logic [2:0] k, logic e, logic l);
      tok_exp_t t;
      if (pending_toks.size() == 0) begin
        $error("unexpected token transaction: tok_byte %02h tok_kind %0d", b, k);
        errors++;
        return;
      end
      t = pending_toks.pop_front();
      if (b !== t.tok_byte) begin
        $error("tok_byte: expected %02h, got %02h", t.tok_byte, b);
        errors++;
      end
      if (k !== t.tok_kind) begin
        $error("tok_kind: expected %0d, got %0d", t.tok_kind, k);
        errors++;
      end
      if (e !== t.end_mark) begin
        $error("is_end_marker: expected %0b, got %0b", t.end_mark, e);
        errors++;
      end
      if (l !== t.run_last) begin
        $error("run_last: expected %0b, got %0b", t.run_last, l);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending_toks.size() != 0) begin
        $error("%0d token transactions never arrived", pending_toks.size());
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/sv/pgn_byte_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgn_byte_tokenizer_tb
// Drives game-record text into the tokenizer with random gaps and output
// stalls: a short directed text for the corner cases, then random tags,
// comments, move numbers, moves, outcomes, digit runs and noise. Each token
// transaction is checked against the predictor, field by field.
// ----------------------------------------------------------------------------
module pgn_byte_tokenizer_tb;

  import pgnt_pkg::*;
  import pgn_tok_tb_pkg::*;

  localparam int RANDOM_BYTES = 320;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  pgn_token_predictor tokens;
  logic [7:0] text_q [$];
  int         bytes_sent = 0;
  int         cycles     = 0;
  bit         in_calm    = 1'b0;
  bit         out_calm   = 1'b0;

  pgn_byte_tokenizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    tokens.take_byte(b, eot);
    bytes_sent++;
    if (bytes_sent % 32 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_str(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Append a fixed string to the text queue
  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Append one random token and up to two separators to the text queue
  task automatic build_token();
    int    sel;
    int    n;
    string spaces;
    logic [7:0] c;
    spaces = " \t\n\013\f\r";
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      text_q.push_back(CH_LBRACKET);
      n = $urandom_range(0, 6);
      repeat (n) text_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
      text_q.push_back(pick(spaces));
      text_q.push_back(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        text_q.push_back(c == CH_QUOTE ? 8'h27 : c);
      end
      text_q.push_back(CH_QUOTE);
      text_q.push_back("]");
    end else if (sel < 25) begin
      text_q.push_back(CH_LBRACE);
      n = $urandom_range(0, 10);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        text_q.push_back(c == CH_RBRACE ? 8'h7c : c);
      end
      text_q.push_back(CH_RBRACE);
    end else if (sel < 40) begin
      n = $urandom_range(1, 3);
      repeat (n) text_q.push_back(pick("0123456789"));
      text_q.push_back(CH_DOT);
      if ($urandom_range(0, 3) == 0) begin
        text_q.push_back(CH_DOT);
        text_q.push_back(CH_DOT);
      end
    end else if (sel < 70) begin
      if ($urandom_range(0, 4) == 0) text_q.push_back(pick("xyzPS=(!?"));
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(pick("NBRQKabcdefgh12345678O0-+#x="));
    end else if (sel < 80) begin
      case ($urandom_range(0, 3))
        0: push_text("1-0");
        1: push_text("0-1");
        2: push_text("1/2-1/2");
        default: begin
          n = $urandom_range(1, 11);
          repeat (n) text_q.push_back(pick("0123456789"));
          text_q.push_back($urandom_range(0, 1) ? CH_DASH : CH_SLASH);
          n = $urandom_range(1, 4);
          repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end else if (sel < 90) begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(pick("0123456789"));
      text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) != 0) text_q.push_back(pick(spaces));
    if ($urandom_range(0, 5) == 0) text_q.push_back(pick(spaces));
  endtask

  // Output side: stall at random, then check each accepted transaction
  initial begin
    int stall;
    int seen;
    seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tokens.match_tok(out_tdata, out_tuser[2:0], out_tuser[3], out_tlast);
      seen++;
      if (seen % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [7:0] b;
    bit         eot;
    tokens = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty key and value, empty comment, move number then a scanned word
    send_str("[ \"\"]", 1'b0);
    send_str("{}", 1'b0);
    send_str("9.x", 1'b0);
    // zero byte ends the scan; move closed by end of text
    send_byte(CH_NUL, 1'b0);
    send_byte("Q", 1'b0);
    send_byte(8'hff, 1'b1);
    // more digits than the store holds, flushed as an outcome; end of text on the dash
    send_str("123456789-", 1'b1);
    send_str("5/a\t", 1'b0);
    // digits before an unrelated byte are dropped
    send_str("7z", 1'b1);

    while (bytes_sent < RANDOM_BYTES + 29) begin
      build_token();
      eot = ($urandom_range(0, 19) == 0);
      while (text_q.size() > 0) begin
        b = text_q.pop_front();
        send_byte(b, (eot && text_q.size() == 0) || $urandom_range(0, 79) == 0);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (tokens.pending_toks.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    tokens.check_drained();
    if (tokens.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
